// File: src/snapshot_ring_index_manager_core_macros.svh
// assertion macros for the snapshot ring index manager
`ifndef SNAPSHOT_RING_INDEX_MANAGER_CORE_MACROS_SVH
`define SNAPSHOT_RING_INDEX_MANAGER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SRIM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SRIM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define SRIM_ASSERT(lbl, clk, rstn, prop, msg)
`define SRIM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: src/srim_pkg.sv
// types, constants and helper functions of the snapshot ring index manager
`timescale 1ns / 1ps
`default_nettype none

package srim_pkg;

  localparam int MAX_SLOTS      = 256;
  localparam int MEMORY_BYTES   = 67108864;
  localparam int FRAMES_PER_SEC = 60;

  localparam int SLOT_W  = 8;
  localparam int CNT_W   = 9;
  localparam int SIZE_W  = 27;
  localparam int FC_W    = 8;
  localparam int HS_W    = 10;
  localparam int FUNC_W  = 3;
  localparam int REQ_W   = 2;
  localparam int CFG_W   = 2;

  // shared divider
  localparam int DIV_W     = SIZE_W;
  localparam int NUM_A_W   = 16;
  localparam int STEP_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_POP    = 3'd1,
    FN_SEEK   = 3'd2,
    FN_COMMIT = 3'd3,
    FN_ACTIVE = 3'd4,
    FN_RESET  = 3'd5
  } func_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE = 2'd0,
    REQ_SAVE = 2'd1,
    REQ_LOAD = 2'd2
  } req_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_FPS        = 2'd1,
    CFG_SECONDS    = 2'd2,
    CFG_SLOT_BYTES = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_A,
    ST_CLAMP,
    ST_DIV_B,
    ST_CAP,
    ST_READ,
    ST_EXEC
  } state_e;

  // slot holding the snapshot of a given age, head below capacity, age below count
  function automatic logic [SLOT_W-1:0] slot_of_age(input logic [SLOT_W-1:0] head,
                                                    input logic [CNT_W-1:0]  cap,
                                                    input logic [SLOT_W-1:0] age);
    logic [CNT_W:0] d;
    logic [CNT_W:0] r;
    d = {2'b00, head} - {{(CNT_W){1'b0}}, 1'b1} - {2'b00, age};
    r = d[CNT_W] ? (d + {1'b0, cap}) : d;
    return r[SLOT_W-1:0];
  endfunction

  // one step forward around the ring
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] s;
    s = {1'b0, idx} + {{(CNT_W-1){1'b0}}, 1'b1};
    return (s == cap) ? '0 : s[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/snapshot_ring_index_manager_core.sv
// snapshot ring index manager: slot bookkeeping, capacity divider and result register
`timescale 1ns / 1ps
`default_nettype none

`include "snapshot_ring_index_manager_core_macros.svh"

// Keeps head, count, seek age and recorded sizes for a ring of saved snapshots and
// answers every input word with one result word naming the slot to save or load.
// Words are taken one at a time; s_axis_tready is high only while the block is idle.
// A pop or seek passes the start, read and exec states; a commit, set active, blocked
// tick, reset that finds storage unusable or unused code passes start and exec only.
// A frame tick that goes ahead and a reset that finds storage usable refresh the
// ring capacity through one shared restoring divider, one quotient bit a cycle:
// 16 steps for the frames-per-snapshot division and, when a slot size is set, 27 more
// for the memory-per-slot division. The block returns to idle as the result is
// registered and takes the next word there. A result waits in the output register
// while the next word is taken; a result still waiting holds the following word in
// its last step.
// Recorded slot sizes live in a 256-entry memory with one valid flop per entry,
// so a reset word clears them at once with no clearing pass.
module snapshot_ring_index_manager_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [26:0] cfg_wdata_i,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // age[7:0], active_value[8], link_busy[9], machine_loaded[10],
  // machine_running[11], transfer_ok[12], saved_size[39:13]
  input  wire logic [39:0] s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot[7:0], load_size[34:8], success[35], snapshot_count[44:36],
  // ring_capacity_out[53:45], rewinding[54], zero[55]
  output logic [55:0]      m_axis_tdata,
  // request[1:0]
  output logic [1:0]       m_axis_tuser
);

  localparam int SW = srim_pkg::SLOT_W;
  localparam int CW = srim_pkg::CNT_W;
  localparam int ZW = srim_pkg::SIZE_W;
  localparam int DW = srim_pkg::DIV_W;
  localparam int AW = srim_pkg::NUM_A_W;

  // configuration registers
  logic                      enable_q;
  logic [srim_pkg::FC_W-1:0] fps_q;
  logic [srim_pkg::HS_W-1:0] hs_q;
  logic [ZW-1:0]             sb_q;

  // latched input word
  srim_pkg::func_e func_q;
  logic [SW-1:0]   age_q;
  logic            act_q, busy_q, loaded_q, running_q, ok_q;
  logic [ZW-1:0]   ssize_q;

  // ring state
  logic [SW-1:0]             head_q, head_d;
  logic [CW-1:0]             held_q, held_d;
  logic [CW-1:0]             cap_q, cap_d;
  logic [srim_pkg::FC_W-1:0] fc_q, fc_d;
  logic                      flag_q, flag_d;
  logic                      seekv_q, seekv_d;
  logic [SW-1:0]             seek_off_q, seek_off_d;
  logic                      ready_q, ready_d;

  // slot size store
  logic [ZW-1:0]        mem_q [srim_pkg::MAX_SLOTS];
  logic [srim_pkg::MAX_SLOTS-1:0] valid_q;
  logic [ZW-1:0]        rd_q;
  logic                 rd_valid_q;
  logic                 mem_we;
  logic                 clear_valid;

  // shared divider
  logic [DW-1:0]               rem_q, quo_q, dvs_q;
  logic [srim_pkg::STEP_W-1:0] cnt_q;
  logic [DW:0]                 div_r, div_r2;
  logic                        div_ge;
  logic [CW-1:0]               t_q;
  logic [CW-1:0]               cap_new;
  logic [AW-1:0]               num_a;
  logic [srim_pkg::FC_W-1:0]   fps_eff;

  // sequencer
  srim_pkg::state_e state_q, state_d;
  logic in_acc, out_free;
  logic div_load_a, div_load_b, div_step, do_clamp, do_cap, do_read, do_exec;
  logic tick_go, reset_go, need_cap, pop_go, seek_go, commit_go;

  // result
  logic                     m_valid_q;
  logic [55:0]              m_data_q;
  logic [srim_pkg::REQ_W-1:0] m_user_q;
  srim_pkg::req_e           req;
  logic [SW-1:0]            slot;
  logic [ZW-1:0]            lsize;
  logic                     succ;
  logic [SW-1:0]            age_sel;
  logic [SW-1:0]            age_slot;
  logic [srim_pkg::FC_W-1:0] fc_inc;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      fps_q    <= 8'd1;
      hs_q     <= 10'd10;
      sb_q     <= '0;
    end else if (cfg_we_i) begin
      case (srim_pkg::cfg_idx_e'(cfg_idx_i))
        srim_pkg::CFG_ENABLE:     enable_q <= cfg_wdata_i[0];
        srim_pkg::CFG_FPS:        fps_q    <= cfg_wdata_i[srim_pkg::FC_W-1:0];
        srim_pkg::CFG_SECONDS:    hs_q     <= cfg_wdata_i[srim_pkg::HS_W-1:0];
        srim_pkg::CFG_SLOT_BYTES: sb_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= srim_pkg::func_e'(s_axis_tuser);
      age_q     <= s_axis_tdata[7:0];
      act_q     <= s_axis_tdata[8];
      busy_q    <= s_axis_tdata[9];
      loaded_q  <= s_axis_tdata[10];
      running_q <= s_axis_tdata[11];
      ok_q      <= s_axis_tdata[12];
      ssize_q   <= s_axis_tdata[39:13];
    end
  end

  // ---------------------------------------------------------------- conditions
  assign tick_go  = enable_q && !busy_q && ready_q && loaded_q && running_q && !flag_q;
  assign reset_go = enable_q && loaded_q && (sb_q != '0) &&
                    (sb_q <= ZW'(srim_pkg::MEMORY_BYTES));
  assign need_cap = ((func_q == srim_pkg::FN_TICK) && tick_go) ||
                    ((func_q == srim_pkg::FN_RESET) && reset_go);
  assign pop_go   = !busy_q && (held_q != '0) && ready_q && (cap_q != '0);
  assign seek_go  = !busy_q && ({1'b0, age_q} < held_q) && ready_q && (cap_q != '0);
  assign commit_go = seekv_q && (seek_off_q != '0) && ({1'b0, seek_off_q} < held_q) &&
                     (cap_q != '0);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= srim_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      srim_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = srim_pkg::ST_START;
      end
      srim_pkg::ST_START: begin
        if (need_cap) begin
          state_d = srim_pkg::ST_DIV_A;
        end else if (func_q == srim_pkg::FN_POP || func_q == srim_pkg::FN_SEEK) begin
          state_d = srim_pkg::ST_READ;
        end else begin
          state_d = srim_pkg::ST_EXEC;
        end
      end
      srim_pkg::ST_DIV_A: begin
        if (cnt_q == srim_pkg::STEP_W'(1)) state_d = srim_pkg::ST_CLAMP;
      end
      srim_pkg::ST_CLAMP: begin
        state_d = (sb_q != '0) ? srim_pkg::ST_DIV_B : srim_pkg::ST_CAP;
      end
      srim_pkg::ST_DIV_B: begin
        if (cnt_q == srim_pkg::STEP_W'(1)) state_d = srim_pkg::ST_CAP;
      end
      srim_pkg::ST_CAP:  state_d = srim_pkg::ST_EXEC;
      srim_pkg::ST_READ: state_d = srim_pkg::ST_EXEC;
      srim_pkg::ST_EXEC: begin
        if (out_free) state_d = srim_pkg::ST_IDLE;
      end
      default: state_d = srim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_load_a    = 1'b0;
    div_load_b    = 1'b0;
    div_step      = 1'b0;
    do_clamp      = 1'b0;
    do_cap        = 1'b0;
    do_read       = 1'b0;
    do_exec       = 1'b0;
    case (state_q)
      srim_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      srim_pkg::ST_START: div_load_a    = need_cap;
      srim_pkg::ST_DIV_A: div_step      = 1'b1;
      srim_pkg::ST_CLAMP: begin
        do_clamp   = 1'b1;
        div_load_b = (sb_q != '0);
      end
      srim_pkg::ST_DIV_B: div_step = 1'b1;
      srim_pkg::ST_CAP:   do_cap   = 1'b1;
      srim_pkg::ST_READ:  do_read  = 1'b1;
      srim_pkg::ST_EXEC:  do_exec  = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- shared divider
  assign fps_eff = (fps_q == '0) ? srim_pkg::FC_W'(1) : fps_q;
  // ceil(seconds * 60 / fps) numerator
  assign num_a = AW'(AW'(hs_q) * AW'(srim_pkg::FRAMES_PER_SEC)) + AW'(fps_eff) - AW'(1);

  assign div_r  = {rem_q, quo_q[DW-1]};
  assign div_ge = div_r >= {1'b0, dvs_q};
  assign div_r2 = div_ge ? (div_r - {1'b0, dvs_q}) : div_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (div_load_a) begin
      cnt_q <= srim_pkg::STEP_W'(AW);
    end else if (div_load_b) begin
      cnt_q <= srim_pkg::STEP_W'(DW);
    end else if (div_step) begin
      cnt_q <= cnt_q - srim_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load_a) begin
      rem_q <= '0;
      quo_q <= {num_a, {(DW-AW){1'b0}}};
      dvs_q <= DW'(fps_eff);
    end else if (div_load_b) begin
      rem_q <= '0;
      quo_q <= DW'(srim_pkg::MEMORY_BYTES);
      dvs_q <= sb_q;
    end else if (div_step) begin
      rem_q <= div_r2[DW-1:0];
      quo_q <= {quo_q[DW-2:0], div_ge};
    end
  end

  // clamp the frame quotient to one up to the slot limit
  always_ff @(posedge clk_i) begin
    if (do_clamp) begin
      if (quo_q[AW-1:0] == '0) begin
        t_q <= CW'(1);
      end else if (quo_q[AW-1:0] > AW'(srim_pkg::MAX_SLOTS)) begin
        t_q <= CW'(srim_pkg::MAX_SLOTS);
      end else begin
        t_q <= quo_q[CW-1:0];
      end
    end
  end

  assign cap_new = ((sb_q != '0) && (quo_q < DW'(t_q))) ? quo_q[CW-1:0] : t_q;

  // ---------------------------------------------------------------- slot lookup
  always_comb begin
    case (func_q)
      srim_pkg::FN_SEEK:   age_sel = age_q;
      srim_pkg::FN_COMMIT: age_sel = seek_off_q;
      default:             age_sel = '0;
    endcase
  end

  assign age_slot = srim_pkg::slot_of_age(head_q, cap_q, age_sel);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[head_q] <= ssize_q;
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rd_q       <= mem_q[age_slot];
      rd_valid_q <= valid_q[age_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_valid) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[head_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- ring update
  assign fc_inc = fc_q + srim_pkg::FC_W'(1);

  always_comb begin
    head_d      = head_q;
    held_d      = held_q;
    cap_d       = cap_q;
    fc_d        = fc_q;
    flag_d      = flag_q;
    seekv_d     = seekv_q;
    seek_off_d  = seek_off_q;
    ready_d     = ready_q;
    mem_we      = 1'b0;
    clear_valid = 1'b0;
    req         = srim_pkg::REQ_NONE;
    slot        = '0;
    lsize       = '0;
    succ        = 1'b0;

    // any change of capacity empties the ring
    if (do_cap && (cap_new != cap_q)) begin
      cap_d   = cap_new;
      head_d  = '0;
      held_d  = '0;
      seekv_d = 1'b0;
    end

    if (do_exec) begin
      case (func_q)
        srim_pkg::FN_TICK: begin
          if (tick_go && (cap_q != '0)) begin
            if (fc_inc < fps_q) begin
              fc_d = fc_inc;
            end else begin
              fc_d = '0;
              req  = srim_pkg::REQ_SAVE;
              slot = head_q;
              if (ok_q) begin
                mem_we = 1'b1;
                head_d = srim_pkg::next_slot(head_q, cap_q);
                if (held_q < cap_q) held_d = held_q + CW'(1);
              end
            end
          end
        end
        srim_pkg::FN_POP: begin
          if (pop_go) begin
            req     = srim_pkg::REQ_LOAD;
            slot    = age_slot;
            lsize   = rd_valid_q ? rd_q : '0;
            succ    = ok_q;
            head_d  = age_slot;
            held_d  = held_q - CW'(1);
            seekv_d = 1'b0;
          end
        end
        srim_pkg::FN_SEEK: begin
          if (seek_go) begin
            req   = srim_pkg::REQ_LOAD;
            slot  = age_slot;
            lsize = rd_valid_q ? rd_q : '0;
            if (ok_q) begin
              succ       = 1'b1;
              seekv_d    = 1'b1;
              seek_off_d = age_q;
            end
          end
        end
        srim_pkg::FN_COMMIT: begin
          if (commit_go) begin
            head_d = srim_pkg::next_slot(age_slot, cap_q);
            held_d = held_q - {1'b0, seek_off_q};
          end
          seekv_d = 1'b0;
        end
        srim_pkg::FN_ACTIVE: begin
          flag_d = act_q;
          if (!act_q) fc_d = '0;
        end
        srim_pkg::FN_RESET: begin
          head_d      = '0;
          held_d      = '0;
          fc_d        = '0;
          flag_d      = 1'b0;
          seekv_d     = 1'b0;
          clear_valid = 1'b1;
          ready_d     = reset_go;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      held_q     <= '0;
      cap_q      <= '0;
      fc_q       <= '0;
      flag_q     <= 1'b0;
      seekv_q    <= 1'b0;
      seek_off_q <= '0;
      ready_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      held_q     <= held_d;
      cap_q      <= cap_d;
      fc_q       <= fc_d;
      flag_q     <= flag_d;
      seekv_q    <= seekv_d;
      seek_off_q <= seek_off_d;
      ready_q    <= ready_d;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (do_exec) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      m_data_q <= {1'b0, flag_d, cap_d, held_d, succ, lsize, slot};
      m_user_q <= req;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------------------------------------------------------- assertions
  `SRIM_ASSERT(a_held_le_cap, clk_i, rst_ni, held_q <= cap_q, "count above capacity")
  `SRIM_ASSERT_IMP(a_head_in_ring, clk_i, rst_ni, cap_q != '0, head_q < cap_q,
                   "head outside ring")
  `SRIM_ASSERT_IMP(a_seek_in_ring, clk_i, rst_ni, seekv_q, ({1'b0, seek_off_q} < held_q),
                   "seek age beyond held snapshots")
  `SRIM_ASSERT_IMP(a_slot_in_ring, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser != srim_pkg::REQ_NONE),
                   ({1'b0, m_axis_tdata[7:0]} < m_axis_tdata[53:45]),
                   "requested slot outside ring")

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for the snapshot ring index manager core
`timescale 1ns / 1ps

module tb;

  localparam logic [srim_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [srim_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;
  localparam int          SETTLE_CYCLES = 64;
  localparam logic [26:0] SIZE_ALL_ONES = 27'h7FFFFFF;

  typedef struct packed {
    logic [srim_pkg::FUNC_W-1:0] func;
    logic [7:0]                  age;
    logic                        active_value;
    logic                        link_busy;
    logic                        machine_loaded;
    logic                        machine_running;
    logic                        transfer_ok;
    logic [srim_pkg::SIZE_W-1:0] saved_size;
  } ring_word_t;

  typedef struct packed {
    srim_pkg::req_e              req;
    logic [srim_pkg::SLOT_W-1:0] slot;
    logic [srim_pkg::SIZE_W-1:0] load_size;
    logic                        success;
    logic [srim_pkg::CNT_W-1:0]  count;
    logic [srim_pkg::CNT_W-1:0]  capacity;
    logic                        rewinding;
  } ring_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [26:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  snapshot_ring_index_manager_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the configuration and the ring bookkeeping
  logic                        cfg_enable = 1'b0;
  logic [7:0]                  cfg_fps = 8'd1;
  logic [9:0]                  cfg_seconds = 10'd10;
  logic [26:0]                 cfg_slot_bytes = '0;
  logic [srim_pkg::SIZE_W-1:0] rec_size [srim_pkg::MAX_SLOTS];
  int unsigned       head = 0;
  int unsigned       held = 0;
  int unsigned       ring_cap = 0;
  logic [7:0]        frame_cnt = '0;
  bit                rewind_flag = 0;
  bit                seek_set = 0;
  int unsigned       seek_depth = 0;
  bit                store_ready = 0;

  ring_result_t pending_results[$];
  int failures = 0;
  int words_sent = 0;
  int saves_seen = 0;
  int loads_seen = 0;
  int phases_run = 0;

  initial begin
    foreach (rec_size[i]) rec_size[i] = '0;
  end

  function automatic int unsigned capacity_target();
    int unsigned fps;
    int unsigned secs;
    int unsigned t;
    int unsigned lim;
    fps = (cfg_fps == 8'd0) ? 1 : cfg_fps;
    secs = cfg_seconds;
    t = (secs * srim_pkg::FRAMES_PER_SEC + fps - 1) / fps;
    if (t < 1) t = 1;
    if (t > srim_pkg::MAX_SLOTS) t = srim_pkg::MAX_SLOTS;
    if (cfg_slot_bytes != '0) begin
      lim = srim_pkg::MEMORY_BYTES / cfg_slot_bytes;
      if (lim < t) t = lim;
    end
    return t;
  endfunction

  // a new capacity empties the ring
  function automatic void update_ring_cap();
    int unsigned t;
    t = capacity_target();
    if (t != ring_cap) begin
      ring_cap = t;
      head = 0;
      held = 0;
      seek_set = 0;
    end
  endfunction

  function automatic int unsigned slot_at_age(input int unsigned a);
    return (head + ring_cap * 2 - 1 - a) % ring_cap;
  endfunction

  function automatic ring_result_t apply_word(input ring_word_t w);
    ring_result_t r;
    int unsigned s;
    r = '0;
    r.req = srim_pkg::REQ_NONE;
    case (w.func)
      srim_pkg::FN_TICK: begin
        if (cfg_enable && !w.link_busy && store_ready && w.machine_loaded &&
            w.machine_running && !rewind_flag) begin
          update_ring_cap();
          if (ring_cap != 0) begin
            frame_cnt = frame_cnt + 8'd1;
            if (frame_cnt >= cfg_fps) begin
              frame_cnt = '0;
              r.req = srim_pkg::REQ_SAVE;
              r.slot = srim_pkg::SLOT_W'(head);
              if (w.transfer_ok) begin
                rec_size[head % srim_pkg::MAX_SLOTS] = w.saved_size;
                head = (head + 1) % ring_cap;
                if (held < ring_cap) held++;
              end
            end
          end
        end
      end
      srim_pkg::FN_POP: begin
        if (!w.link_busy && held != 0 && store_ready && ring_cap != 0) begin
          s = slot_at_age(0);
          r.req = srim_pkg::REQ_LOAD;
          r.slot = srim_pkg::SLOT_W'(s);
          r.load_size = rec_size[s % srim_pkg::MAX_SLOTS];
          r.success = w.transfer_ok;
          head = s;
          held--;
          seek_set = 0;
        end
      end
      srim_pkg::FN_SEEK: begin
        if (!w.link_busy && w.age < held && store_ready && ring_cap != 0) begin
          s = slot_at_age(w.age);
          r.req = srim_pkg::REQ_LOAD;
          r.slot = srim_pkg::SLOT_W'(s);
          r.load_size = rec_size[s % srim_pkg::MAX_SLOTS];
          if (w.transfer_ok) begin
            r.success = 1'b1;
            seek_set = 1;
            seek_depth = w.age;
          end
        end
      end
      srim_pkg::FN_COMMIT: begin
        if (seek_set && seek_depth > 0 && seek_depth < held && ring_cap > 0) begin
          s = slot_at_age(seek_depth);
          head = (s + 1) % ring_cap;
          held = held - seek_depth;
        end
        seek_set = 0;
      end
      srim_pkg::FN_ACTIVE: begin
        rewind_flag = w.active_value;
        if (!w.active_value) frame_cnt = '0;
      end
      srim_pkg::FN_RESET: begin
        head = 0;
        held = 0;
        frame_cnt = '0;
        rewind_flag = 0;
        seek_set = 0;
        foreach (rec_size[i]) rec_size[i] = '0;
        if (!cfg_enable || !w.machine_loaded || cfg_slot_bytes == '0 ||
            cfg_slot_bytes > srim_pkg::MEMORY_BYTES) begin
          store_ready = 0;
        end else begin
          update_ring_cap();
          store_ready = 1;
        end
      end
      default: ;
    endcase
    r.count = srim_pkg::CNT_W'(held);
    r.capacity = srim_pkg::CNT_W'(ring_cap);
    r.rewinding = rewind_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  int rx_cycle = 0;
  int stall_left = 0;

  // a new stall starts only when the cycle count modulo 1024 is 256 or more
  always @(negedge clk_i) begin
    rx_cycle++;
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      if ((rx_cycle % 1024) >= 256 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 20);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    ring_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: request %0d data %h",
               m_axis_tuser, m_axis_tdata);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("request", exp_r.req, m_axis_tuser);
        check_field("slot", exp_r.slot, m_axis_tdata[7:0]);
        check_field("load_size", exp_r.load_size, m_axis_tdata[34:8]);
        check_field("success", exp_r.success, m_axis_tdata[35]);
        check_field("snapshot_count", exp_r.count, m_axis_tdata[44:36]);
        check_field("ring_capacity_out", exp_r.capacity, m_axis_tdata[53:45]);
        check_field("rewinding", exp_r.rewinding, m_axis_tdata[54]);
        if (m_axis_tuser == srim_pkg::REQ_SAVE) saves_seen++;
        if (m_axis_tuser == srim_pkg::REQ_LOAD) loads_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_word(input ring_word_t w);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = w.func;
    s_axis_tdata = {w.saved_size, w.transfer_ok, w.machine_running, w.machine_loaded,
                    w.link_busy, w.active_value, w.age};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_word(w));
    words_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // stop sending until every result is back, then let the block go quiet
  task automatic drain_results(input int extra);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input srim_pkg::cfg_idx_e idx, input logic [26:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      srim_pkg::CFG_ENABLE:     cfg_enable = value[0];
      srim_pkg::CFG_FPS:        cfg_fps = value[7:0];
      srim_pkg::CFG_SECONDS:    cfg_seconds = value[9:0];
      srim_pkg::CFG_SLOT_BYTES: cfg_slot_bytes = value;
      default: ;
    endcase
  endtask

  task automatic configure_ring(input logic en, input logic [7:0] fps,
                                input logic [9:0] secs, input logic [26:0] bytes);
    drain_results(SETTLE_CYCLES);
    write_reg(srim_pkg::CFG_ENABLE, {26'd0, en});
    write_reg(srim_pkg::CFG_FPS, {19'd0, fps});
    write_reg(srim_pkg::CFG_SECONDS, {17'd0, secs});
    write_reg(srim_pkg::CFG_SLOT_BYTES, bytes);
  endtask

  // well-behaved word: machine loaded and running, link free, transfer good
  function automatic ring_word_t plain_word(input logic [srim_pkg::FUNC_W-1:0] f);
    ring_word_t w;
    w = '0;
    w.func = f;
    w.machine_loaded = 1'b1;
    w.machine_running = 1'b1;
    w.transfer_ok = 1'b1;
    w.saved_size = srim_pkg::SIZE_W'($urandom_range(0, SIZE_ALL_ONES));
    return w;
  endfunction

  function automatic ring_word_t random_word();
    ring_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: every field at random
      w.func = srim_pkg::FUNC_W'($urandom_range(0, 7));
      w.age = 8'($urandom_range(0, 255));
      w.active_value = 1'($urandom_range(0, 1));
      w.link_busy = 1'($urandom_range(0, 1));
      w.machine_loaded = 1'($urandom_range(0, 1));
      w.machine_running = 1'($urandom_range(0, 1));
      w.transfer_ok = 1'($urandom_range(0, 1));
      w.saved_size = srim_pkg::SIZE_W'($urandom_range(0, SIZE_ALL_ONES));
      return w;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) w = plain_word(srim_pkg::FN_TICK);
    else if (pick < 62) w = plain_word(srim_pkg::FN_POP);
    else if (pick < 77) w = plain_word(srim_pkg::FN_SEEK);
    else if (pick < 86) w = plain_word(srim_pkg::FN_COMMIT);
    else if (pick < 94) w = plain_word(srim_pkg::FN_ACTIVE);
    else if (pick < 98) w = plain_word(srim_pkg::FN_RESET);
    else w = plain_word($urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7);
    if ($urandom_range(0, 9) == 0) w.age = 8'($urandom_range(0, 255));
    else w.age = 8'($urandom_range(0, (held > 255) ? 255 : held));
    // leave rewinding quickly so ticks are not held off for long
    w.active_value = rewind_flag ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 2) == 0);
    w.link_busy = ($urandom_range(0, 11) == 0);
    w.machine_loaded = ($urandom_range(0, 19) != 0);
    w.machine_running = ($urandom_range(0, 14) != 0);
    w.transfer_ok = ($urandom_range(0, 5) != 0);
    return w;
  endfunction

  task automatic run_random_words(input int n);
    int burst_left;
    burst_left = 0;
    repeat (n) begin
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
      if ($urandom_range(0, 79) == 0) drain_results(0);
      send_word(random_word());
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_storage_unusable();
    ring_word_t w;
    send_word(plain_word(srim_pkg::FN_TICK));
    send_word(plain_word(srim_pkg::FN_POP));
    send_word(plain_word(srim_pkg::FN_SEEK));
    send_word(plain_word(srim_pkg::FN_COMMIT));
    send_word(plain_word(FN_SPARE_6));
    w = plain_word(srim_pkg::FN_ACTIVE);
    w.active_value = 1'b1;
    send_word(w);
    send_word(plain_word(srim_pkg::FN_ACTIVE));
  endtask

  task automatic test_save_and_wrap();
    ring_word_t w;
    // four-slot ring limited by slot size
    configure_ring(1'b1, 8'd1, 10'd10, 27'd16777216);
    send_word(plain_word(srim_pkg::FN_RESET));
    w = plain_word(srim_pkg::FN_TICK);
    w.saved_size = '0;
    send_word(w);
    w.saved_size = SIZE_ALL_ONES;
    send_word(w);
    w.transfer_ok = 1'b0;
    send_word(w);
    repeat (3) send_word(plain_word(srim_pkg::FN_TICK));
  endtask

  task automatic test_pop_seek_commit();
    ring_word_t w;
    w = plain_word(srim_pkg::FN_SEEK);
    w.age = 8'd255;
    send_word(w);
    w.age = 8'd2;
    send_word(w);
    send_word(plain_word(srim_pkg::FN_COMMIT));
    w.age = 8'd1;
    w.transfer_ok = 1'b0;
    send_word(w);
    send_word(plain_word(srim_pkg::FN_COMMIT));
    w = plain_word(srim_pkg::FN_SEEK);
    send_word(w);
    send_word(plain_word(srim_pkg::FN_COMMIT));
    w = plain_word(srim_pkg::FN_POP);
    w.transfer_ok = 1'b0;
    send_word(w);
  endtask

  task automatic test_blocked_ticks();
    ring_word_t w;
    w = plain_word(srim_pkg::FN_TICK);
    w.link_busy = 1'b1;
    send_word(w);
    w = plain_word(srim_pkg::FN_TICK);
    w.machine_running = 1'b0;
    send_word(w);
    w = plain_word(srim_pkg::FN_ACTIVE);
    w.active_value = 1'b1;
    send_word(w);
    send_word(plain_word(srim_pkg::FN_TICK));
  endtask

  task automatic test_zero_capacity();
    // slot size raised past memory while storage stays usable
    configure_ring(1'b1, 8'd0, 10'd0, 27'd67108865);
    send_word(plain_word(srim_pkg::FN_TICK));
    send_word(plain_word(srim_pkg::FN_POP));
    send_word(plain_word(srim_pkg::FN_RESET));
  endtask

  task automatic test_random_phases();
    logic [26:0] bytes;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: configure_ring(1'b1, 8'd1, 10'd10, 27'd16777216);
        1: configure_ring(1'b1, 8'd0, 10'd600, 27'd1);
        2: configure_ring(1'b1, 8'd3, 10'd1, 27'd67108864);
        3: configure_ring(1'b1, 8'($urandom_range(1, 4)), 10'($urandom_range(0, 1023)),
                          27'($urandom_range(1, srim_pkg::MEMORY_BYTES)));
        4: configure_ring(1'b1, 8'd1, 10'($urandom_range(1, 5)), cfg_slot_bytes);
        5: configure_ring(1'b1, 8'd1, 10'd10, SIZE_ALL_ONES);
        6: configure_ring(1'b0, 8'd2, 10'd1023, 27'd4096);
        7: configure_ring(1'b1, 8'd255, 10'd600, 27'd1048576);
        default: begin
          bytes = ($urandom_range(0, 3) == 0) ? 27'($urandom_range(0, SIZE_ALL_ONES))
                                              : 27'($urandom_range(1, 262144));
          configure_ring(1'b1, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                         bytes);
        end
      endcase
      // phases four and five keep the ring from before so the capacity change bites
      if (p != 4 && p != 5) send_word(plain_word(srim_pkg::FN_RESET));
      case (p)
        0: run_random_words(150);
        1: run_random_words(220);
        2: run_random_words(100);
        3: run_random_words(180);
        4: run_random_words(100);
        5: run_random_words(50);
        6: run_random_words(40);
        7: run_random_words(200);
        default: run_random_words(150);
      endcase
      phases_run++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_storage_unusable();
    test_save_and_wrap();
    test_pop_seek_commit();
    test_blocked_ticks();
    test_zero_capacity();
    test_random_phases();
    drain_results(SETTLE_CYCLES * 2);
    $display("sent %0d words over %0d random configurations plus directed cases",
             words_sent, phases_run);
    $display("results checked include %0d save and %0d load requests", saves_seen, loads_seen);
    if (failures == 0) begin
      $display("PASS snapshot_ring_index_manager_core");
    end else begin
      $display("FAIL snapshot_ring_index_manager_core");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL snapshot_ring_index_manager_core");
    $finish;
  end

endmodule
